@@ sv/url_scheme_host_port_parser_top_assert.svh @@
// Assertion macros for the URL scheme/host/port parser.
// Each check is sampled on clk and disabled while rst_n is low.
`ifndef URL_SCHEME_HOST_PORT_PARSER_TOP_ASSERT_SVH
`define URL_SCHEME_HOST_PORT_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define USHP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ushp assertion failed");

`define USHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ushp assertion failed");

`else

`define USHP_ASSERT_NOW(label, ante, cons)

`define USHP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ sv/ushp_pkg.sv @@
package ushp_pkg;

    localparam int MAX_LEN = 1024;
    localparam int LEN_W   = 10;
    localparam int PORT_W  = 16;
    localparam int CHAR_W  = 8;
    localparam int OUT_W   = 56;

    localparam logic [LEN_W-1:0]  LEN_LIM  = LEN_W'(MAX_LEN - 1);
    localparam logic [PORT_W-1:0] PORT_LIM = '1;

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SCHEME = 2'd1;
    localparam logic [1:0] ST_NO_SLASH  = 2'd2;
    localparam logic [1:0] ST_NO_PORT   = 2'd3;

    // Field order matches the output word, lowest bits last in this list.
    typedef struct packed {
        logic [PORT_W-1:0] port_value;
        logic              port_present;
        logic [LEN_W-1:0]  host_length;
        logic [LEN_W-1:0]  host_start;
        logic [LEN_W-1:0]  scheme_length;
        logic [1:0]        status;
    } ushp_result_t;

endpackage

@@ sv/ushp_parse.sv @@
module ushp_parse
    import ushp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [CHAR_W-1:0]  char_byte,
    output ushp_result_t       result
);

    typedef enum logic [2:0] {
        PH_SCHEME,
        PH_SLASH1,
        PH_SLASH2,
        PH_HOST,
        PH_PORT,
        PH_DONE,
        PH_FAIL
    } phase_t;

    phase_t              phase_reg,   phase_next;
    logic [LEN_W-1:0]    scheme_len_reg, scheme_len_next;
    logic [LEN_W-1:0]    host_len_reg,   host_len_next;
    logic [3:0]          depth_reg,   depth_next;
    logic [PORT_W-1:0]   port_reg,    port_next;
    logic                digits_reg,  digits_next;
    logic [1:0]          status_reg,  status_next;

    logic [LEN_W-1:0]    scheme_inc;
    logic [LEN_W-1:0]    host_inc;
    logic [LEN_W:0]      host_start_sum;
    logic [LEN_W-1:0]    host_start_sat;
    logic [3:0]          digit;
    logic [PORT_W+3:0]   port_prod;
    logic                is_digit;
    logic [1:0]          st;

    assign scheme_inc     = (scheme_len_reg == LEN_LIM) ? LEN_LIM : scheme_len_reg + 1'b1;
    assign host_inc       = (host_len_reg == LEN_LIM) ? LEN_LIM : host_len_reg + 1'b1;
    assign host_start_sum = {1'b0, scheme_len_reg} + (LEN_W+1)'(3);
    assign host_start_sat = (host_start_sum > {1'b0, LEN_LIM}) ? LEN_LIM
                                                              : host_start_sum[LEN_W-1:0];

    assign is_digit  = char_byte inside {[CH_ZERO:CH_NINE]};
    assign digit     = 4'(char_byte - CH_ZERO);
    // accum * 10 as two shifted copies
    assign port_prod = {1'b0, port_reg, 3'b000} + {3'b000, port_reg, 1'b0}
                     + {16'd0, digit};

    // Result for a terminator seen in the current state
    always_comb
    begin
        case (phase_reg)
            PH_SCHEME: st = ST_NO_SCHEME;
            PH_SLASH1,
            PH_SLASH2: st = ST_NO_SLASH;
            PH_HOST,
            PH_DONE:   st = ST_OK;
            PH_PORT:   st = digits_reg ? ST_OK : ST_NO_PORT;
            default:   st = status_reg;
        endcase

        result               = '0;
        result.status        = st;
        if (st != ST_NO_SCHEME)
        begin
            result.scheme_length = scheme_len_reg;
        end
        if (st == ST_OK || st == ST_NO_PORT)
        begin
            result.host_start  = host_start_sat;
            result.host_length = host_len_reg;
        end
        if (st == ST_OK && digits_reg)
        begin
            result.port_present = 1'b1;
            result.port_value   = port_reg;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        scheme_len_next = scheme_len_reg;
        host_len_next   = host_len_reg;
        depth_next      = depth_reg;
        port_next       = port_reg;
        digits_next     = digits_reg;
        status_next     = status_reg;

        if (step)
        begin
            if (char_byte == CH_NUL)
            begin
                phase_next      = PH_SCHEME;
                scheme_len_next = '0;
                host_len_next   = '0;
                depth_next      = '0;
                port_next       = '0;
                digits_next     = 1'b0;
                status_next     = ST_OK;
            end
            else
            begin
                case (phase_reg)
                    PH_SCHEME:
                    begin
                        if (char_byte == CH_COLON)
                        begin
                            if (scheme_len_reg == '0)
                            begin
                                status_next = ST_NO_SCHEME;
                                phase_next  = PH_FAIL;
                            end
                            else
                            begin
                                phase_next = PH_SLASH1;
                            end
                        end
                        else
                        begin
                            scheme_len_next = scheme_inc;
                        end
                    end
                    PH_SLASH1,
                    PH_SLASH2:
                    begin
                        if (char_byte == CH_SLASH)
                        begin
                            phase_next = (phase_reg == PH_SLASH1) ? PH_SLASH2 : PH_HOST;
                        end
                        else
                        begin
                            status_next = ST_NO_SLASH;
                            phase_next  = PH_FAIL;
                        end
                    end
                    PH_HOST:
                    begin
                        if ((char_byte == CH_COLON || char_byte == CH_SLASH)
                            && depth_reg == '0)
                        begin
                            phase_next = (char_byte == CH_COLON) ? PH_PORT : PH_DONE;
                        end
                        else
                        begin
                            if (char_byte == CH_LBRACK)
                            begin
                                depth_next = depth_reg + 1'b1;
                            end
                            else if (char_byte == CH_RBRACK)
                            begin
                                depth_next = depth_reg - 1'b1;
                            end
                            host_len_next = host_inc;
                        end
                    end
                    PH_PORT:
                    begin
                        if (is_digit)
                        begin
                            port_next   = (port_prod > {4'd0, PORT_LIM}) ? PORT_LIM
                                                                         : port_prod[PORT_W-1:0];
                            digits_next = 1'b1;
                        end
                        else if (digits_reg)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            status_next = ST_NO_PORT;
                            phase_next  = PH_FAIL;
                        end
                    end
                    default:
                    begin
                        // parse finished: drop bytes until the terminator
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SCHEME;
            scheme_len_reg <= '0;
            host_len_reg   <= '0;
            depth_reg      <= '0;
            port_reg       <= '0;
            digits_reg     <= 1'b0;
            status_reg     <= ST_OK;
        end
        else
        begin
            phase_reg      <= phase_next;
            scheme_len_reg <= scheme_len_next;
            host_len_reg   <= host_len_next;
            depth_reg      <= depth_next;
            port_reg       <= port_next;
            digits_reg     <= digits_next;
            status_reg     <= status_next;
        end
    end

endmodule

@@ sv/url_scheme_host_port_parser_top.sv @@
// Channel   Dir  Width  Contents
// s_*       in   8      tdata: char_byte[7:0]; zero byte ends the URL
// m_*       out  56     tdata: status, scheme_length, host_start, host_length,
//                       port_present, port_value, zero pad
//
// One byte per cycle is sustained unless a terminator waits on a stalled result;
// a byte sits in the input register, then the parse state and, on a terminator,
// the result register are updated. m_tvalid is set with the result register.
// Reset returns the parser to the scheme phase with all counters cleared.
// Only a terminator waits on a full, stalled result register; other bytes
// keep flowing while a result is held.
module url_scheme_host_port_parser_top
    import ushp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,   // [7:0] char_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // [1:0] status, [11:2] scheme_length,
                                         // [21:12] host_start, [31:22] host_length,
                                         // [32] port_present, [48:33] port_value
);

    logic                in_valid_reg;
    logic [CHAR_W-1:0]   in_char_reg;
    logic                out_valid_reg;
    ushp_result_t        out_reg;
    ushp_result_t        result;
    logic                is_term;
    logic                advance;
    logic                load_result;

    assign is_term  = (in_char_reg == CH_NUL);
    // hold a terminator only while the result register is full and stalled
    assign advance  = in_valid_reg && (!is_term || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign load_result = advance && is_term;

    ushp_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .char_byte (in_char_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
        end
        if (load_result)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - $bits(ushp_result_t)){1'b0}}, out_reg};

`include "url_scheme_host_port_parser_top_assert.svh"

    `USHP_ASSERT_NEXT(a_term_loads_result, load_result, m_tvalid)
    `USHP_ASSERT_NEXT(a_drain_without_term, out_valid_reg && m_tready && !load_result, !m_tvalid)
    `USHP_ASSERT_NOW(a_port_only_when_ok, m_tvalid && m_tdata[32], m_tdata[1:0] == ST_OK)
    `USHP_ASSERT_NOW(a_no_scheme_zeroes, m_tvalid && m_tdata[1:0] == ST_NO_SCHEME, m_tdata[48:2] == '0)
    `USHP_ASSERT_NOW(a_stall_only_on_term, in_valid_reg && !advance, is_term && out_valid_reg && !m_tready)

endmodule

@@ dv/ushp_result_checker.sv @@
`timescale 1ns / 1ps

module ushp_result_checker
    import ushp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,
    output int unsigned       fail_count,
    output int unsigned       results_owed,
    output int unsigned       urls_checked
);

    localparam int RES_W = $bits(ushp_result_t);

    typedef enum logic [2:0] {
        PH_SCHEME,
        PH_SLASH1,
        PH_SLASH2,
        PH_HOST,
        PH_PORT,
        PH_DONE,
        PH_FAIL
    } parse_phase_t;

    parse_phase_t      phase;
    logic [LEN_W-1:0]  scheme_cnt;
    logic [LEN_W-1:0]  host_cnt;
    logic [3:0]        depth;
    logic [PORT_W-1:0] port_acc;
    logic              port_seen;
    logic [1:0]        fail_code;

    ushp_result_t      url_results[$];

    function automatic logic [LEN_W-1:0] len_sat(input logic [LEN_W-1:0] v, input int add);
        int sum;
        sum = int'(v) + add;
        return (sum > int'(LEN_LIM)) ? LEN_LIM : LEN_W'(sum);
    endfunction

    task automatic clear_parse();
        phase      = PH_SCHEME;
        scheme_cnt = '0;
        host_cnt   = '0;
        depth      = '0;
        port_acc   = '0;
        port_seen  = 1'b0;
        fail_code  = ST_OK;
    endtask

    task automatic parse_char(input logic [CHAR_W-1:0] c);
        ushp_result_t r;
        int unsigned  acc;
        bit           ends_host;
        if (c == CH_NUL) begin
            r = '0;
            case (phase)
                PH_SCHEME:          r.status = ST_NO_SCHEME;
                PH_SLASH1, PH_SLASH2: r.status = ST_NO_SLASH;
                PH_HOST, PH_DONE:   r.status = ST_OK;
                PH_PORT:            r.status = port_seen ? ST_OK : ST_NO_PORT;
                default:            r.status = fail_code;
            endcase
            if (r.status != ST_NO_SCHEME)
                r.scheme_length = scheme_cnt;
            if (r.status == ST_OK || r.status == ST_NO_PORT) begin
                r.host_start  = len_sat(scheme_cnt, 3);
                r.host_length = host_cnt;
            end
            if (r.status == ST_OK && port_seen) begin
                r.port_present = 1'b1;
                r.port_value   = port_acc;
            end
            url_results.push_back(r);
            clear_parse();
        end
        else begin
            case (phase)
                PH_SCHEME:
                    if (c == CH_COLON) begin
                        if (scheme_cnt == '0) begin
                            fail_code = ST_NO_SCHEME;
                            phase     = PH_FAIL;
                        end
                        else
                            phase = PH_SLASH1;
                    end
                    else
                        scheme_cnt = len_sat(scheme_cnt, 1);
                PH_SLASH1, PH_SLASH2:
                    if (c == CH_SLASH)
                        phase = (phase == PH_SLASH1) ? PH_SLASH2 : PH_HOST;
                    else begin
                        fail_code = ST_NO_SLASH;
                        phase     = PH_FAIL;
                    end
                PH_HOST:
                begin
                    ends_host = 1'b0;
                    if (c == CH_LBRACK)
                        depth = depth + 4'd1;
                    else if (c == CH_RBRACK)
                        depth = depth - 4'd1;
                    else if ((c == CH_COLON || c == CH_SLASH) && depth == '0) begin
                        phase     = (c == CH_COLON) ? PH_PORT : PH_DONE;
                        ends_host = 1'b1;
                    end
                    // bracket bytes belong to the host
                    if (!ends_host)
                        host_cnt = len_sat(host_cnt, 1);
                end
                PH_PORT:
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                        acc       = port_acc * 10 + (c - CH_ZERO);
                        port_acc  = (acc > 65535) ? PORT_LIM : PORT_W'(acc);
                        port_seen = 1'b1;
                    end
                    else if (port_seen)
                        phase = PH_DONE;
                    else begin
                        fail_code = ST_NO_PORT;
                        phase     = PH_FAIL;
                    end
                default:
                    ;
            endcase
        end
    endtask

    task automatic check_field(input string what, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ushp_result_t want;
        ushp_result_t got;
        if (!rst_n) begin
            clear_parse();
            url_results.delete();
            results_owed = 0;
        end
        else begin
            if (s_tvalid && s_tready)
                parse_char(s_tdata);
            if (m_tvalid && m_tready) begin
                got = ushp_result_t'(m_tdata[RES_W-1:0]);
                if (url_results.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, m_tdata);
                    fail_count++;
                end
                else begin
                    want = url_results.pop_front();
                    check_field("status",        want.status,        got.status);
                    check_field("scheme_length", want.scheme_length, got.scheme_length);
                    check_field("host_start",    want.host_start,    got.host_start);
                    check_field("host_length",   want.host_length,   got.host_length);
                    check_field("port_present",  want.port_present,  got.port_present);
                    check_field("port_value",    want.port_value,    got.port_value);
                    check_field("pad",           0,                  m_tdata[OUT_W-1:RES_W]);
                    urls_checked++;
                end
            end
            results_owed = url_results.size();
        end
    end

endmodule

@@ dv/url_scheme_host_port_parser_top_tb.sv @@
`timescale 1ns / 1ps

module url_scheme_host_port_parser_top_tb;
    import ushp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_LEN    = 400;
    localparam int PHASE_BYTES = 90;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [CHAR_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    int unsigned fail_count;
    int unsigned results_owed;
    int unsigned urls_checked;

    int unsigned src_idle  = 0;
    int unsigned snk_stall = 0;
    bit          hold_req  = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_cycles = 0;
    int unsigned bytes_sent  = 0;
    int unsigned cycle_count = 0;

    logic [CHAR_W-1:0] url_text[$];

    url_scheme_host_port_parser_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ushp_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .results_owed (results_owed),
        .urls_checked (urls_checked)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL url_scheme_host_port_parser_top");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off when asked.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_req && !hold_done) begin
            m_tready <= 1'b0;
            hold_cycles++;
            if (hold_cycles >= HOLD_LEN)
                hold_done = 1'b1;
        end
        else
            m_tready <= ($urandom_range(99) >= snk_stall);
    end

    // Call at a falling edge; returns at the falling edge after the word is taken.
    task automatic push_char(input logic [CHAR_W-1:0] c);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic push_text();
        foreach (url_text[i])
            push_char(url_text[i]);
        push_char(CH_NUL);
    endtask

    task automatic push_string(input string s);
        url_text.delete();
        for (int i = 0; i < s.len(); i++)
            url_text.push_back(s[i]);
        push_text();
    endtask

    function automatic logic [CHAR_W-1:0] pick_from(input string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    task automatic add_random_bytes(input int n);
        for (int i = 0; i < n; i++)
            url_text.push_back(CHAR_W'($urandom_range(1, 255)));
    endtask

    // Mostly well-formed URLs with random content; the rest is broken or noise.
    task automatic gen_url();
        int unsigned       pick;
        int                n;
        logic [CHAR_W-1:0] c;
        url_text.delete();
        pick = $urandom_range(99);
        if (pick < 8) begin
            add_random_bytes($urandom_range(1, 24));
            return;
        end
        n = ($urandom_range(99) < 4) ? 0 : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            c = ($urandom_range(99) < 10) ? CHAR_W'($urandom_range(1, 255))
                                          : pick_from("abcdefghijklmnopqrstuvwxyz+.-");
            url_text.push_back((c == CH_COLON) ? "x" : c);
        end
        if ($urandom_range(99) >= 3)
            url_text.push_back(CH_COLON);
        pick = $urandom_range(99);
        if (pick < 4)
            url_text.push_back(CH_SLASH);
        else if (pick < 8)
            add_random_bytes(1);
        else begin
            url_text.push_back(CH_SLASH);
            url_text.push_back(CH_SLASH);
        end
        pick = $urandom_range(99);
        if (pick < 15) begin
            url_text.push_back(CH_LBRACK);
            n = $urandom_range(2, 10);
            for (int i = 0; i < n; i++)
                url_text.push_back(pick_from("0123456789abcdef::"));
            url_text.push_back(CH_RBRACK);
        end
        else if (pick < 22) begin
            // unbalanced and wrapping bracket depth
            n = $urandom_range(1, 18);
            for (int i = 0; i < n; i++)
                url_text.push_back(pick_from("[[[]h:"));
        end
        else begin
            n = $urandom_range(0, 12);
            for (int i = 0; i < n; i++)
                url_text.push_back(pick_from("abcdefghijklmnopqrstuvwxyz0123456789.-"));
        end
        pick = $urandom_range(99);
        if (pick < 30)
            return;
        if (pick < 75) begin
            url_text.push_back(CH_COLON);
            pick = $urandom_range(99);
            n = (pick < 10) ? 0 : (pick < 85) ? $urandom_range(1, 5) : $urandom_range(6, 9);
            for (int i = 0; i < n; i++)
                url_text.push_back(($urandom_range(99) < 20) ? CH_NINE : pick_from("0123456789"));
        end
        else
            url_text.push_back(CH_SLASH);
        if ($urandom_range(99) < 60)
            add_random_bytes($urandom_range(0, 6));
    endtask

    // Saturates scheme length, host start and port in one URL.
    task automatic gen_long_url();
        url_text.delete();
        repeat (1024) url_text.push_back("a");
        url_text.push_back(CH_COLON);
        url_text.push_back(CH_SLASH);
        url_text.push_back(CH_SLASH);
        repeat (8) url_text.push_back("b");
        url_text.push_back(CH_COLON);
        repeat (7) url_text.push_back(CH_NINE);
    endtask

    task automatic run_pace(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned mark;
        src_idle  = idle_pct;
        snk_stall = stall_pct;
        mark      = bytes_sent;
        while (bytes_sent < mark + PHASE_BYTES) begin
            gen_url();
            push_text();
        end
    endtask

    initial
    begin
        string directed_urls[6];
        directed_urls = '{"", ":", "a:", "a:/x", "a://h:", "a://:x"};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_urls[i])
            push_string(directed_urls[i]);

        run_pace(0, 0);
        run_pace(53, 0);
        run_pace(0, 53);
        run_pace(19, 19);

        gen_long_url();
        push_text();

        // hold the result side while bytes keep coming
        src_idle  = 0;
        snk_stall = 0;
        hold_req  = 1'b1;
        repeat (12)
        begin
            gen_url();
            push_text();
        end

        s_tvalid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);

        $display("Sent %0d bytes and checked %0d URL results across four pacing mixes,",
                 bytes_sent, urls_checked);
        $display("a saturating long URL and a %0d-cycle result hold-off.", HOLD_LEN);
        if (fail_count == 0)
            $display("PASS url_scheme_host_port_parser_top");
        else
            $display("FAIL url_scheme_host_port_parser_top");
        $finish;
    end

endmodule
